// ===== rtl/cht_pkg.sv =====
`default_nettype none
package cht_pkg;

    // defaults for the top level parameters
    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_KICKS_DEF = 32;

    // hash modulus, 2^31 + 11
    localparam logic [32:0] HASH_PRIME = 33'd2147483659;

    // configuration reset values
    localparam logic [31:0] A0_RST = 32'd1;
    localparam logic [31:0] B0_RST = 32'd0;
    localparam logic [31:0] A1_RST = 32'd2;
    localparam logic [31:0] B1_RST = 32'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_A0 = 2'd0;
    localparam logic [1:0] CFG_B0 = 2'd1;
    localparam logic [1:0] CFG_A1 = 2'd2;
    localparam logic [1:0] CFG_B1 = 2'd3;

    // operation codes; the fourth code leaves the table unchanged and reports ST_OK
    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_DUPLICATE,
        ST_KICK_LIMIT
    } t_status;

    typedef struct packed {
        logic [31:0] a0;
        logic [31:0] b0;
        logic [31:0] a1;
        logic [31:0] b1;
    } t_hash_cfg;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_MUL,
        HS_ADD,
        HS_FOLD1,
        HS_FOLD,
        HS_FIX,
        HS_MOD,
        HS_DONE
    } t_hash_state;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_HASH,
        FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC,
        BS_KHASH,
        BS_KWAIT,
        BS_KRD,
        BS_KEXEC
    } t_back_state;

endpackage
`default_nettype wire

// ===== rtl/cht_hash.sv =====
`default_nettype none
module cht_hash #(
    parameter int DEPTH = cht_pkg::DEPTH_DEF,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [31:0]       i_key,
    input  wire logic [31:0]       i_a,
    input  wire logic [31:0]       i_b,
    output logic                   o_done,
    output logic [SLOT_W-1:0]      o_slot
);
    import cht_pkg::*;

    // reciprocal of the slot count, ceil(2^(32+SLOT_W) / DEPTH); bit 32 is always set
    localparam logic [63:0] RECIP    = ((64'd1 << (32 + SLOT_W)) + 64'(DEPTH) - 64'd1) /
                                       64'(DEPTH);
    localparam logic [31:0] RECIP_LO = RECIP[31:0];
    localparam logic [31:0] DEPTH_W  = 32'(DEPTH);

    t_hash_state r_state, n_state;
    logic [3:0]  r_cnt;
    logic [31:0] r_key, r_a, r_b;
    logic [63:0] r_prod, r_x;
    logic signed [37:0] r_v;
    logic [31:0] r_res;
    logic [64:0] r_sum;
    logic [SLOT_W-1:0] r_rem;

    logic [63:0] w_prod;
    logic [37:0] w_h1, w_m1;
    logic signed [37:0] w_h, w_m, w_fold, w_fix;
    logic [63:0] w_rmul;
    logic [64:0] w_sum;
    logic [32-SLOT_W:0] w_quo;
    logic [31:0] w_qd, w_rem;

    // 32x32 product, later corrected for the sign extension of the key
    assign w_prod = r_a * r_key;

    // first fold: 2^31 is -11 modulo the prime
    assign w_h1 = {5'b0, r_x[63:31]};
    assign w_m1 = (w_h1 << 3) + (w_h1 << 1) + w_h1;

    // later folds on the signed residue
    assign w_h    = r_v >>> 31;
    assign w_m    = (w_h <<< 3) + (w_h <<< 1) + w_h;
    assign w_fold = $signed({7'b0, r_v[30:0]}) - w_m;
    assign w_fix  = r_v + $signed({5'b0, HASH_PRIME});

    // slot = residue mod DEPTH by reciprocal multiply: the quotient, then the remainder
    assign w_rmul = 64'(r_res) * 64'(RECIP_LO);
    assign w_sum  = {1'b0, r_res, 32'b0} + {1'b0, w_rmul};
    assign w_quo  = r_sum[64:32+SLOT_W];
    assign w_qd   = 32'(w_quo) * DEPTH_W;
    assign w_rem  = r_res - w_qd;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            HS_IDLE:  if (i_start) n_state = HS_MUL;
            HS_MUL:   n_state = HS_ADD;
            HS_ADD:   n_state = HS_FOLD1;
            HS_FOLD1: n_state = HS_FOLD;
            HS_FOLD:  if (r_cnt[0]) n_state = HS_FIX;
            HS_FIX:   n_state = HS_MOD;
            HS_MOD:   if (r_cnt[0]) n_state = HS_DONE;
            HS_DONE:  n_state = HS_IDLE;
            default:  n_state = HS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_state == HS_DONE);
        o_slot = r_rem;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                HS_FOLD, HS_MOD: r_cnt <= r_cnt + 4'd1;
                default:         r_cnt <= '0;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            HS_IDLE: begin
                if (i_start) begin
                    r_key <= i_key;
                    r_a   <= i_a;
                    r_b   <= i_b;
                end
            end
            HS_MUL:   r_prod <= w_prod;
            HS_ADD:   r_x <= r_prod - (r_key[31] ? {r_a, 32'b0} : 64'b0) + {32'b0, r_b};
            HS_FOLD1: r_v <= $signed({7'b0, r_x[30:0]} - w_m1);
            HS_FOLD:  r_v <= w_fold;
            HS_FIX:   r_res <= r_v[37] ? w_fix[31:0] : r_v[31:0];
            HS_MOD: begin
                // the scaled product is registered first, then the remainder from it
                r_sum <= w_sum;
                r_rem <= w_rem[SLOT_W-1:0];
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/cht_front.sv =====
`default_nettype none
module cht_front #(
    parameter int DEPTH = cht_pkg::DEPTH_DEF,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_clearing,
    input  wire cht_pkg::t_hash_cfg i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [31:0] i_key,
    input  wire logic signed [31:0] i_value,
    output logic                    o_job_valid,
    input  wire logic               i_job_pop,
    output logic [1:0]              o_job_op,
    output logic [31:0]             o_job_key,
    output logic [31:0]             o_job_value,
    output logic [SLOT_W-1:0]       o_job_s0,
    output logic [SLOT_W-1:0]       o_job_s1
);
    import cht_pkg::*;

    t_front_state r_state, n_state;
    logic [1:0]  r_op;
    logic [31:0] r_key, r_val;
    logic [SLOT_W-1:0] r_s0, r_s1;

    // two-entry job queue
    logic [1:0]        r_q_op  [2];
    logic [31:0]       r_q_key [2];
    logic [31:0]       r_q_val [2];
    logic [SLOT_W-1:0] r_q_s0  [2];
    logic [SLOT_W-1:0] r_q_s1  [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;

    logic w_accept, w_push, w_done0, w_done1;
    logic [SLOT_W-1:0] w_slot0, w_slot1;

    assign w_accept = i_valid && o_ready;
    assign w_push   = (r_state == FS_PUSH) && (r_cnt != 2'd2);

    // both table hashes run side by side with equal latency
    cht_hash #(.DEPTH(DEPTH)) u_hash0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_key),
        .i_a     (i_cfg.a0),
        .i_b     (i_cfg.b0),
        .o_done  (w_done0),
        .o_slot  (w_slot0)
    );

    cht_hash #(.DEPTH(DEPTH)) u_hash1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_key),
        .i_a     (i_cfg.a1),
        .i_b     (i_cfg.b1),
        .o_done  (w_done1),
        .o_slot  (w_slot1)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: if (w_accept) n_state = FS_HASH;
            FS_HASH: if (w_done0 && w_done1) n_state = FS_PUSH;
            FS_PUSH: if (w_push) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = (r_state == FS_IDLE) && !i_clearing;
        o_job_valid = (r_cnt != 2'd0);
        o_job_op    = r_q_op[r_rp];
        o_job_key   = r_q_key[r_rp];
        o_job_value = r_q_val[r_rp];
        o_job_s0    = r_q_s0[r_rp];
        o_job_s1    = r_q_s1[r_rp];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_push) r_wp <= ~r_wp;
            if (i_job_pop) r_rp <= ~r_rp;
            if (w_push && !i_job_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_job_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // item capture and queue storage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_operation;
            r_key <= i_key;
            r_val <= i_value;
        end
        if ((r_state == FS_HASH) && w_done0) begin
            r_s0 <= w_slot0;
            r_s1 <= w_slot1;
        end
        if (w_push) begin
            r_q_op[r_wp]  <= r_op;
            r_q_key[r_wp] <= r_key;
            r_q_val[r_wp] <= r_val;
            r_q_s0[r_wp]  <= r_s0;
            r_q_s1[r_wp]  <= r_s1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cht_back.sv =====
`default_nettype none
module cht_back #(
    parameter int DEPTH     = cht_pkg::DEPTH_DEF,
    parameter int MAX_KICKS = cht_pkg::MAX_KICKS_DEF,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cht_pkg::t_hash_cfg i_cfg,
    output logic                    o_clearing,
    input  wire logic               i_job_valid,
    output logic                    o_job_pop,
    input  wire logic [1:0]         i_job_op,
    input  wire logic [31:0]        i_job_key,
    input  wire logic [31:0]        i_job_value,
    input  wire logic [SLOT_W-1:0]  i_job_s0,
    input  wire logic [SLOT_W-1:0]  i_job_s1,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_found_value,
    output logic signed [31:0]      o_evicted_key,
    output logic signed [31:0]      o_evicted_value,
    output logic [11:0]             o_entry_count
);
    import cht_pkg::*;

    localparam int COUNT_W = $clog2(2 * DEPTH + 1);
    localparam int KICK_W  = $clog2(MAX_KICKS + 1);

    // table words: valid, key, data
    logic [64:0] r_mem0 [DEPTH];
    logic [64:0] r_mem1 [DEPTH];
    logic [64:0] r_q0, r_q1;

    t_back_state r_state, n_state;
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]  r_op, n_op;
    logic [31:0] r_key, n_key, r_val, n_val;
    logic [SLOT_W-1:0] r_s0, n_s0, r_s1, n_s1, r_kslot, n_kslot;
    logic [31:0] r_ck, n_ck, r_cv, n_cv;
    logic        r_tab, n_tab;
    logic [KICK_W-1:0] r_kick, n_kick;
    logic        r_ov, n_ov;
    t_status     r_status, n_status;
    logic [31:0] r_found, n_found, r_ek, n_ek, r_ev, n_ev;

    logic        w_we0, w_we1;
    logic [SLOT_W-1:0] w_wa0, w_wa1, w_ra0, w_ra1;
    logic [64:0] w_wd0, w_wd1;
    logic        w_hstart, w_hdone;
    logic [SLOT_W-1:0] w_hslot;
    logic        w_hit0, w_hit1, w_chain;
    logic [64:0] w_qt;
    logic [KICK_W-1:0] w_kick_nx;
    logic [COUNT_W+11:0] w_cnt_ext;

    assign w_hit0    = r_q0[64] && (r_q0[63:32] == r_key);
    assign w_hit1    = r_q1[64] && (r_q1[63:32] == r_key);
    assign w_chain   = (r_op == OP_INSERT) && !w_hit0 && !w_hit1 && r_q0[64] && r_q1[64];
    assign w_qt      = r_tab ? r_q1 : r_q0;
    assign w_kick_nx = r_kick + 1'b1;

    // hash unit for the slot of each displaced entry
    cht_hash #(.DEPTH(DEPTH)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_key   (r_ck),
        .i_a     (r_tab ? i_cfg.a1 : i_cfg.a0),
        .i_b     (r_tab ? i_cfg.b1 : i_cfg.b0),
        .o_done  (w_hdone),
        .o_slot  (w_hslot)
    );

    // table memories, registered reads
    always_ff @(posedge i_clk) begin
        if (w_we0) r_mem0[w_wa0] <= w_wd0;
        if (w_we1) r_mem1[w_wa1] <= w_wd1;
        r_q0 <= r_mem0[w_ra0];
        r_q1 <= r_mem1[w_ra1];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: if (r_clr == SLOT_W'(DEPTH - 1)) n_state = BS_IDLE;
            BS_IDLE:  if (i_job_valid && !r_ov) n_state = BS_EXEC;
            BS_EXEC:  n_state = (w_chain && (MAX_KICKS > 1)) ? BS_KHASH : BS_IDLE;
            BS_KHASH: n_state = BS_KWAIT;
            BS_KWAIT: if (w_hdone) n_state = BS_KRD;
            BS_KRD:   n_state = BS_KEXEC;
            BS_KEXEC: begin
                if (!w_qt[64] || (w_kick_nx == KICK_W'(MAX_KICKS))) begin
                    n_state = BS_IDLE;
                end else begin
                    n_state = BS_KHASH;
                end
            end
            default:  n_state = BS_IDLE;
        endcase
    end

    // outputs, memory strobes and register updates
    always_comb begin
        w_we0     = 1'b0;
        w_we1     = 1'b0;
        w_wa0     = r_kslot;
        w_wa1     = r_kslot;
        w_wd0     = {1'b1, r_ck, r_cv};
        w_wd1     = {1'b1, r_ck, r_cv};
        w_ra0     = r_kslot;
        w_ra1     = r_kslot;
        w_hstart  = 1'b0;
        o_job_pop = 1'b0;
        n_clr     = r_clr;
        n_count   = r_count;
        n_op      = r_op;
        n_key     = r_key;
        n_val     = r_val;
        n_s0      = r_s0;
        n_s1      = r_s1;
        n_kslot   = r_kslot;
        n_ck      = r_ck;
        n_cv      = r_cv;
        n_tab     = r_tab;
        n_kick    = r_kick;
        n_ov      = r_ov && !i_ready;
        n_status  = r_status;
        n_found   = r_found;
        n_ek      = r_ek;
        n_ev      = r_ev;
        case (r_state)
            BS_CLEAR: begin
                w_we0 = 1'b1;
                w_we1 = 1'b1;
                w_wa0 = r_clr;
                w_wa1 = r_clr;
                w_wd0 = '0;
                w_wd1 = '0;
                n_clr = r_clr + 1'b1;
            end
            BS_IDLE: begin
                w_ra0 = i_job_s0;
                w_ra1 = i_job_s1;
                if (i_job_valid && !r_ov) begin
                    o_job_pop = 1'b1;
                    n_op  = i_job_op;
                    n_key = i_job_key;
                    n_val = i_job_value;
                    n_s0  = i_job_s0;
                    n_s1  = i_job_s1;
                end
            end
            BS_EXEC: begin
                n_ov     = 1'b1;
                n_status = ST_OK;
                n_found  = '0;
                n_ek     = '0;
                n_ev     = '0;
                case (r_op)
                    OP_SEARCH: begin
                        if (w_hit0) begin
                            n_found = r_q0[31:0];
                        end else if (w_hit1) begin
                            n_found = r_q1[31:0];
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    OP_ERASE: begin
                        w_wa0 = r_s0;
                        w_wa1 = r_s1;
                        w_wd0 = '0;
                        w_wd1 = '0;
                        if (w_hit0) begin
                            w_we0   = 1'b1;
                            n_count = r_count - 1'b1;
                        end else if (w_hit1) begin
                            w_we1   = 1'b1;
                            n_count = r_count - 1'b1;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    OP_INSERT: begin
                        w_wa0 = r_s0;
                        w_wa1 = r_s1;
                        w_wd0 = {1'b1, r_key, r_val};
                        w_wd1 = {1'b1, r_key, r_val};
                        if (w_hit0 || w_hit1) begin
                            n_status = ST_DUPLICATE;
                        end else if (!r_q0[64]) begin
                            w_we0   = 1'b1;
                            n_count = r_count + 1'b1;
                        end else if (!r_q1[64]) begin
                            w_we1   = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            // first move: new entry takes its table zero slot
                            w_we0  = 1'b1;
                            n_ck   = r_q0[63:32];
                            n_cv   = r_q0[31:0];
                            n_tab  = 1'b1;
                            n_kick = KICK_W'(1);
                            if (MAX_KICKS > 1) begin
                                n_ov = 1'b0;
                            end else begin
                                n_status = ST_KICK_LIMIT;
                                n_ek     = r_q0[63:32];
                                n_ev     = r_q0[31:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            BS_KHASH: w_hstart = 1'b1;
            BS_KWAIT: if (w_hdone) n_kslot = w_hslot;
            BS_KRD: ;
            BS_KEXEC: begin
                w_we0 = !r_tab;
                w_we1 = r_tab;
                if (!w_qt[64]) begin
                    n_count  = r_count + 1'b1;
                    n_ov     = 1'b1;
                    n_status = ST_OK;
                    n_found  = '0;
                    n_ek     = '0;
                    n_ev     = '0;
                end else begin
                    n_ck   = w_qt[63:32];
                    n_cv   = w_qt[31:0];
                    n_tab  = ~r_tab;
                    n_kick = w_kick_nx;
                    if (w_kick_nx == KICK_W'(MAX_KICKS)) begin
                        n_ov     = 1'b1;
                        n_status = ST_KICK_LIMIT;
                        n_found  = '0;
                        n_ek     = w_qt[63:32];
                        n_ev     = w_qt[31:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // job and result registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_s0     <= n_s0;
        r_s1     <= n_s1;
        r_kslot  <= n_kslot;
        r_ck     <= n_ck;
        r_cv     <= n_cv;
        r_tab    <= n_tab;
        r_kick   <= n_kick;
        r_status <= n_status;
        r_found  <= n_found;
        r_ek     <= n_ek;
        r_ev     <= n_ev;
    end

    assign w_cnt_ext       = {12'b0, r_count};
    assign o_clearing      = (r_state == BS_CLEAR);
    assign o_valid         = r_ov;
    assign o_status        = r_status;
    assign o_found_value   = r_found;
    assign o_evicted_key   = r_ek;
    assign o_evicted_value = r_ev;
    assign o_entry_count   = w_cnt_ext[11:0];

endmodule
`default_nettype wire

// ===== rtl/cuckoo_hash_table_unit.sv =====
// Flow: from input transfer to result, a search, erase or direct insert passes
// through the front (both table hashes in parallel), then through the back.
// Each displacement move after the first adds a hash, a table read and a write.
// The front takes a new item only after it has hashed and queued the last one.
// Reset: synchronous, active low; then a clearing pass over every slot of both
// tables with o_ready low. Configuration writes are taken at any time.
`default_nettype none
module cuckoo_hash_table_unit #(
    parameter int DEPTH     = cht_pkg::DEPTH_DEF,
    parameter int MAX_KICKS = cht_pkg::MAX_KICKS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [31:0] i_key,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_found_value,
    output logic signed [31:0]      o_evicted_key,
    output logic signed [31:0]      o_evicted_value,
    output logic [11:0]             o_entry_count
);
    import cht_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);

    t_hash_cfg r_cfg;
    logic w_clearing, w_job_valid, w_job_pop;
    logic [1:0]  w_job_op;
    logic [31:0] w_job_key, w_job_value;
    logic [SLOT_W-1:0] w_job_s0, w_job_s1;

    // hash configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{a0: A0_RST, b0: B0_RST, a1: A1_RST, b1: B1_RST};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_A0:  r_cfg.a0 <= i_cfg_data;
                CFG_B0:  r_cfg.b0 <= i_cfg_data;
                CFG_A1:  r_cfg.a1 <= i_cfg_data;
                CFG_B1:  r_cfg.b1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cht_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clearing  (w_clearing),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop),
        .o_job_op    (w_job_op),
        .o_job_key   (w_job_key),
        .o_job_value (w_job_value),
        .o_job_s0    (w_job_s0),
        .o_job_s1    (w_job_s1)
    );

    cht_back #(.DEPTH(DEPTH), .MAX_KICKS(MAX_KICKS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .o_clearing      (w_clearing),
        .i_job_valid     (w_job_valid),
        .o_job_pop       (w_job_pop),
        .i_job_op        (w_job_op),
        .i_job_key       (w_job_key),
        .i_job_value     (w_job_value),
        .i_job_s0        (w_job_s0),
        .i_job_s1        (w_job_s1),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_found_value   (o_found_value),
        .o_evicted_key   (o_evicted_key),
        .o_evicted_value (o_evicted_value),
        .o_entry_count   (o_entry_count)
    );

    // no transfers in during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_ready)
        else $error("item accepted during clearing pass");

    // no results during the clearing pass
    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_valid)
        else $error("result presented during clearing pass");

    // the queue is only popped when it holds a job
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> w_job_valid)
        else $error("job queue popped while empty");

endmodule
`default_nettype wire
